@@ src/ilp_pkg.sv @@
// ----------------------------------------------------------------------------
// ilp_pkg
// Shared types, codes and helpers of the integer literal parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ilp_pkg;

  // width of the parsed value and of the output data bus
  localparam int VALUE_WIDTH = 32;
  localparam int TDATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8;

  // character codes
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_LO_X   = 8'h78;
  localparam logic [7:0] CH_UP_X   = 8'h58;
  localparam logic [7:0] CH_LO_B   = 8'h62;
  localparam logic [7:0] CH_UP_B   = 8'h42;
  localparam logic [7:0] CH_LO_O   = 8'h6f;
  localparam logic [7:0] CH_UP_O   = 8'h4f;

  // digit value marking a character that is no digit at all
  localparam logic [4:0] DIGIT_NONE = 5'd16;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_SIGNED = 3'd1,
    PH_ZERO   = 3'd2,
    PH_PREFIX = 3'd3,
    PH_DIGITS = 3'd4,
    PH_FAIL   = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_HEX = 2'd1,
    RX_BIN = 2'd2,
    RX_OCT = 2'd3
  } radix_t;

  typedef struct packed {
    phase_t                   phase;
    logic                     is_negative;
    radix_t                   radix;
    logic [VALUE_WIDTH-1:0]   acc;
    logic                     seen_char;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:       PH_START,
    is_negative: 1'b0,
    radix:       RX_DEC,
    acc:         '0,
    seen_char:   1'b0
  };

  // value of a digit character, DIGIT_NONE when it is none
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
    end else if (c >= CH_LO_A && c <= CH_LO_F) begin
      d = c - CH_LO_A + 8'd10;
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      d = c - CH_UP_A + 8'd10;
    end else begin
      d = {3'b000, DIGIT_NONE};
    end
    return d[4:0];
  endfunction

  // number of digit values allowed in a radix
  function automatic logic [4:0] radix_base(input radix_t r);
    logic [4:0] b;
    case (r)
      RX_DEC:  b = 5'd10;
      RX_HEX:  b = 5'd16;
      RX_BIN:  b = 5'd2;
      RX_OCT:  b = 5'd8;
      default: b = 5'd10;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ src/integer_literal_parser.sv @@
// ----------------------------------------------------------------------------
// integer_literal_parser
// Parses a signed integer literal with optional 0x/0b/0o prefix, one
// character per item, and gives value, ok and truth on the last character.
// ----------------------------------------------------------------------------
// path: input register, then the step into state and result register (m_*)
// throughput: one character per cycle unless an untaken result holds the last
//   character; set by the single shift-add accumulator update in that step
// reset: synchronous, clears the input and result valid flags and the
//   parse state; no clearing pass
`default_nettype none

module integer_literal_parser (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [7:0]                      s_tdata,   // char_code
  input  wire logic                            s_tlast,   // last
  input  wire logic                            s_tuser,   // no_char
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [ilp_pkg::TDATA_WIDTH-1:0]      m_tdata,   // value
  output logic [1:0]                           m_tuser    // ok, truth
);

  logic                  in_valid;
  logic [7:0]            in_char;
  logic                  in_last;
  logic                  in_no_char;
  logic                  consume;
  ilp_pkg::parse_state_t state;
  ilp_pkg::parse_state_t state_next;

  // the held item moves on unless it ends a string and the result is stuck
  assign consume  = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || consume;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_char    <= s_tdata;
      in_last    <= s_tlast;
      in_no_char <= s_tuser;
    end
  end

  ilp_step u_step (
    .cur       (state),
    .char_code (in_char),
    .no_char   (in_no_char),
    .nxt       (state_next)
  );

  // parse state, back to start after each string
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ilp_pkg::STATE_RESET;
    end else if (consume) begin
      state <= in_last ? ilp_pkg::STATE_RESET : state_next;
    end
  end

  ilp_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (consume && in_last),
    .fin      (state_next),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

@@ src/ilp_step.sv @@
// ----------------------------------------------------------------------------
// ilp_step
// Next parse state for one character: sign, prefix and digit handling.
// ----------------------------------------------------------------------------
`default_nettype none

module ilp_step (
  input  wire ilp_pkg::parse_state_t cur,
  input  wire logic [7:0]            char_code,
  input  wire logic                  no_char,
  output ilp_pkg::parse_state_t      nxt
);

  logic [4:0]                      digit;
  logic                            digit_ok;
  logic [ilp_pkg::VALUE_WIDTH-1:0] scaled;
  logic [ilp_pkg::VALUE_WIDTH-1:0] acc_mac;

  // digit decode and multiply-add by the radix, done as shifts
  always_comb begin
    digit    = ilp_pkg::digit_of(char_code);
    digit_ok = digit < ilp_pkg::radix_base(cur.radix);
    case (cur.radix)
      ilp_pkg::RX_DEC: scaled = (cur.acc << 3) + (cur.acc << 1);
      ilp_pkg::RX_HEX: scaled = cur.acc << 4;
      ilp_pkg::RX_BIN: scaled = cur.acc << 1;
      ilp_pkg::RX_OCT: scaled = cur.acc << 3;
      default:         scaled = cur.acc;
    endcase
    acc_mac = scaled + {{(ilp_pkg::VALUE_WIDTH-5){1'b0}}, digit};
  end

  // phase transitions
  always_comb begin
    nxt = cur;
    if (!no_char) begin
      nxt.seen_char = 1'b1;
      case (cur.phase)
        ilp_pkg::PH_START, ilp_pkg::PH_SIGNED: begin
          if (cur.phase == ilp_pkg::PH_START && char_code == ilp_pkg::CH_PLUS) begin
            nxt.phase = ilp_pkg::PH_SIGNED;
          end else if (cur.phase == ilp_pkg::PH_START &&
                       char_code == ilp_pkg::CH_MINUS) begin
            nxt.phase       = ilp_pkg::PH_SIGNED;
            nxt.is_negative = 1'b1;
          end else if (char_code == ilp_pkg::CH_ZERO) begin
            nxt.phase = ilp_pkg::PH_ZERO;
          end else if (digit_ok) begin
            nxt.acc   = acc_mac;
            nxt.phase = ilp_pkg::PH_DIGITS;
          end else begin
            nxt.phase = ilp_pkg::PH_FAIL;
          end
        end
        ilp_pkg::PH_ZERO: begin
          if (char_code == ilp_pkg::CH_LO_X || char_code == ilp_pkg::CH_UP_X) begin
            nxt.radix = ilp_pkg::RX_HEX;
            nxt.phase = ilp_pkg::PH_PREFIX;
          end else if (char_code == ilp_pkg::CH_LO_B || char_code == ilp_pkg::CH_UP_B) begin
            nxt.radix = ilp_pkg::RX_BIN;
            nxt.phase = ilp_pkg::PH_PREFIX;
          end else if (char_code == ilp_pkg::CH_LO_O || char_code == ilp_pkg::CH_UP_O) begin
            nxt.radix = ilp_pkg::RX_OCT;
            nxt.phase = ilp_pkg::PH_PREFIX;
          end else if (digit_ok) begin
            nxt.acc   = acc_mac;
            nxt.phase = ilp_pkg::PH_DIGITS;
          end else begin
            nxt.phase = ilp_pkg::PH_FAIL;
          end
        end
        ilp_pkg::PH_PREFIX, ilp_pkg::PH_DIGITS: begin
          if (digit_ok) begin
            nxt.acc   = acc_mac;
            nxt.phase = ilp_pkg::PH_DIGITS;
          end else begin
            nxt.phase = ilp_pkg::PH_FAIL;
          end
        end
        default: begin
          nxt.phase = ilp_pkg::PH_FAIL;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/ilp_out.sv @@
// ----------------------------------------------------------------------------
// ilp_out
// Result register: final sign, ok and truth flags, master-side handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module ilp_out (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            load,
  input  wire ilp_pkg::parse_state_t           fin,
  input  wire logic                            m_tready,
  output logic                                 m_tvalid,
  output logic [ilp_pkg::TDATA_WIDTH-1:0]      m_tdata,
  output logic [1:0]                           m_tuser
);

  logic                            ok;
  logic [ilp_pkg::VALUE_WIDTH-1:0] val;
  logic                            truth;
  logic [ilp_pkg::TDATA_WIDTH-1:0] data_next;

  // final value of the string
  always_comb begin
    ok  = fin.phase == ilp_pkg::PH_ZERO || fin.phase == ilp_pkg::PH_DIGITS;
    val = '0;
    if (ok) begin
      val = fin.is_negative ? (-fin.acc) : fin.acc;
    end
    truth = ok ? (val != '0) : fin.seen_char;
    data_next = '0;
    data_next[ilp_pkg::VALUE_WIDTH-1:0] = val;
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= data_next;
      m_tuser <= {truth, ok};
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/tb_integer_literal_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_literal_parser
// Feeds strings one character per item into the parser: directed corner
// strings first, then random literals, broken literals and noise, under
// several source idle and sink stall mixes. A scoreboard tracks the parse
// of every accepted character and checks each result in order.
// ----------------------------------------------------------------------------

module tb_integer_literal_parser;

  localparam int RANDOM_ITEMS = 1650;
  localparam int HOLD_CYCLES  = 200;

  typedef logic [7:0] char_q_t[$];

  typedef struct {
    logic [ilp_pkg::VALUE_WIDTH-1:0] value;
    logic                            ok;
    logic                            truth;
  } literal_result_t;

  // value of a digit character in any radix, DIGIT_NONE if not a digit
  function automatic logic [4:0] char_digit(input logic [7:0] c);
    if (c >= ilp_pkg::CH_ZERO && c <= ilp_pkg::CH_NINE) return 5'(c - ilp_pkg::CH_ZERO);
    if (c >= ilp_pkg::CH_LO_A && c <= ilp_pkg::CH_LO_F) begin
      return 5'(c - ilp_pkg::CH_LO_A + 8'd10);
    end
    if (c >= ilp_pkg::CH_UP_A && c <= ilp_pkg::CH_UP_F) begin
      return 5'(c - ilp_pkg::CH_UP_A + 8'd10);
    end
    return ilp_pkg::DIGIT_NONE;
  endfunction

  // tracks the parse of the current string and holds pending results
  class parse_scoreboard;
    ilp_pkg::phase_t                 ph;
    logic                            neg;
    ilp_pkg::radix_t                 rdx;
    logic [ilp_pkg::VALUE_WIDTH-1:0] acc;
    logic                            seen;
    literal_result_t                 expected_q[$];
    int                              errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      ph   = ilp_pkg::PH_START;
      neg  = 1'b0;
      rdx  = ilp_pkg::RX_DEC;
      acc  = '0;
      seen = 1'b0;
    endfunction

    function void fold_digit(input logic [7:0] c);
      logic [4:0]                      d;
      logic [4:0]                      base;
      logic [ilp_pkg::VALUE_WIDTH-1:0] mult;
      logic [ilp_pkg::VALUE_WIDTH-1:0] dx;
      d = char_digit(c);
      case (rdx)
        ilp_pkg::RX_HEX: base = 5'd16;
        ilp_pkg::RX_BIN: base = 5'd2;
        ilp_pkg::RX_OCT: base = 5'd8;
        default:         base = 5'd10;
      endcase
      if (d >= base) begin
        ph = ilp_pkg::PH_FAIL;
      end else begin
        mult = {{(ilp_pkg::VALUE_WIDTH-5){1'b0}}, base};
        dx   = {{(ilp_pkg::VALUE_WIDTH-5){1'b0}}, d};
        acc  = acc * mult + dx;
        ph   = ilp_pkg::PH_DIGITS;
      end
    endfunction

    function void after_sign(input logic [7:0] c);
      if (c == ilp_pkg::CH_ZERO) ph = ilp_pkg::PH_ZERO;
      else fold_digit(c);
    endfunction

    function void step_char(input logic [7:0] c);
      case (ph)
        ilp_pkg::PH_START: begin
          if (c == ilp_pkg::CH_PLUS) begin
            ph = ilp_pkg::PH_SIGNED;
          end else if (c == ilp_pkg::CH_MINUS) begin
            ph  = ilp_pkg::PH_SIGNED;
            neg = 1'b1;
          end else begin
            after_sign(c);
          end
        end
        ilp_pkg::PH_SIGNED: after_sign(c);
        ilp_pkg::PH_ZERO: begin
          if (c == ilp_pkg::CH_LO_X || c == ilp_pkg::CH_UP_X) begin
            rdx = ilp_pkg::RX_HEX;
            ph  = ilp_pkg::PH_PREFIX;
          end else if (c == ilp_pkg::CH_LO_B || c == ilp_pkg::CH_UP_B) begin
            rdx = ilp_pkg::RX_BIN;
            ph  = ilp_pkg::PH_PREFIX;
          end else if (c == ilp_pkg::CH_LO_O || c == ilp_pkg::CH_UP_O) begin
            rdx = ilp_pkg::RX_OCT;
            ph  = ilp_pkg::PH_PREFIX;
          end else begin
            fold_digit(c);
          end
        end
        ilp_pkg::PH_PREFIX, ilp_pkg::PH_DIGITS: fold_digit(c);
        default: ph = ilp_pkg::PH_FAIL;
      endcase
    endfunction

    // one accepted character item
    function void note_char(input logic [7:0] c, input logic lst, input logic nc);
      literal_result_t r;
      if (!nc) begin
        seen = 1'b1;
        step_char(c);
      end
      if (!lst) return;
      r.ok    = (ph == ilp_pkg::PH_ZERO || ph == ilp_pkg::PH_DIGITS);
      r.value = '0;
      if (r.ok) r.value = neg ? -acc : acc;
      r.truth = r.ok ? (r.value != '0) : seen;
      expected_q.push_back(r);
      clear();
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task flag_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      errors++;
    endtask

    // one accepted result item
    task check_result(input logic [ilp_pkg::TDATA_WIDTH-1:0] data, input logic [1:0] user);
      literal_result_t r;
      if (expected_q.size() == 0) begin
        flag_mismatch("unexpected result", 64'(data), 64'(0));
        return;
      end
      r = expected_q.pop_front();
      if (data[ilp_pkg::VALUE_WIDTH-1:0] !== r.value) begin
        flag_mismatch("value", 64'(data), 64'(r.value));
      end
      if (user[0] !== r.ok) flag_mismatch("ok", 64'(user[0]), 64'(r.ok));
      if (user[1] !== r.truth) flag_mismatch("truth", 64'(user[1]), 64'(r.truth));
    endtask

    task check_drained();
      if (expected_q.size() != 0) begin
        flag_mismatch("results left over", 64'(0), 64'(expected_q.size()));
      end
    endtask
  endclass

  logic                            clk;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [7:0]                      s_tdata;
  logic                            s_tlast;
  logic                            s_tuser;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [ilp_pkg::TDATA_WIDTH-1:0] m_tdata;
  logic [1:0]                      m_tuser;

  parse_scoreboard sb = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  bit hold_request   = 1'b0;
  int items_sent     = 0;

  integer_literal_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("tb_integer_literal_parser: done, errors");
    $finish;
  end

  // sink ready, with random stalls and one long hold-off
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result check
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  // offer one item, called at a falling edge, returns at a falling edge
  task automatic send_item(input logic [7:0] c, input logic lst, input logic nc);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= lst;
    s_tuser  <= nc;
    do @(posedge clk); while (!s_tready);
    sb.note_char(c, lst, nc);
    if (!nc || lst) items_sent++;
    @(negedge clk);
  endtask

  // one string, with stray empty items now and then
  task automatic send_string(input char_q_t chars, input bit end_empty);
    for (int i = 0; i < chars.size(); i++) begin
      if ($urandom_range(24) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
      send_item(chars[i], !end_empty && i == chars.size() - 1, 1'b0);
    end
    if (end_empty || chars.size() == 0) send_item(8'($urandom_range(255)), 1'b1, 1'b1);
  endtask

  task automatic send_text(input string s, input bit end_empty);
    char_q_t q;
    foreach (s[i]) q.push_back(s[i]);
    send_string(q, end_empty);
  endtask

  function automatic logic [7:0] digit_char(input int d, input bit up);
    if (d < 10) return ilp_pkg::CH_ZERO + 8'(d);
    return (up ? ilp_pkg::CH_UP_A : ilp_pkg::CH_LO_A) + 8'(d - 10);
  endfunction

  function automatic logic [7:0] prefix_char(input ilp_pkg::radix_t r, input bit up);
    case (r)
      ilp_pkg::RX_HEX: return up ? ilp_pkg::CH_UP_X : ilp_pkg::CH_LO_X;
      ilp_pkg::RX_BIN: return up ? ilp_pkg::CH_UP_B : ilp_pkg::CH_LO_B;
      default:         return up ? ilp_pkg::CH_UP_O : ilp_pkg::CH_LO_O;
    endcase
  endfunction

  // random literal: mostly well formed, some broken, some noise
  task automatic build_literal(output char_q_t chars);
    ilp_pkg::radix_t r;
    int              n;
    int              kind;
    int              pick;
    int              base;
    bit              up;
    logic [7:0]      sign_ch;
    logic [7:0]      bad;
    chars = {};
    kind  = $urandom_range(99);
    if (kind >= 90) begin
      n = $urandom_range(1, 6);
      repeat (n) chars.push_back(8'($urandom_range(255)));
      return;
    end
    pick    = $urandom_range(2);
    sign_ch = (pick == 2) ? ilp_pkg::CH_MINUS : ilp_pkg::CH_PLUS;
    if (pick != 0) chars.push_back(sign_ch);
    up   = 1'($urandom_range(1));
    r    = ilp_pkg::RX_DEC;
    base = 10;
    pick = $urandom_range(99);
    if (pick < 10) begin
      chars.push_back(ilp_pkg::CH_ZERO);
    end else if (pick < 45) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
      repeat (n) chars.push_back(digit_char($urandom_range(base - 1), up));
    end else begin
      pick = $urandom_range(2);
      r    = (pick == 0) ? ilp_pkg::RX_HEX : (pick == 1) ? ilp_pkg::RX_BIN : ilp_pkg::RX_OCT;
      base = (r == ilp_pkg::RX_HEX) ? 16 : (r == ilp_pkg::RX_BIN) ? 2 : 8;
      chars.push_back(ilp_pkg::CH_ZERO);
      chars.push_back(prefix_char(r, up));
      n = ($urandom_range(7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      repeat (n) chars.push_back(digit_char($urandom_range(base - 1), 1'($urandom_range(1))));
    end
    if (kind < 70) return;
    // break the literal
    case ($urandom_range(3))
      0: chars[$urandom_range(chars.size() - 1)] = 8'($urandom_range(255));
      1: begin
        bad = (r == ilp_pkg::RX_HEX) ? prefix_char(ilp_pkg::RX_OCT, up)
                                     : digit_char($urandom_range(base, 15), up);
        chars.insert($urandom_range(chars.size()), bad);
      end
      2: begin
        chars = {};
        if ($urandom_range(1)) chars.push_back(sign_ch);
        if ($urandom_range(1) || chars.size() == 0) begin
          chars.push_back(ilp_pkg::CH_ZERO);
          chars.push_back(prefix_char(r == ilp_pkg::RX_DEC ? ilp_pkg::RX_HEX : r, up));
        end
      end
      default: chars.push_front($urandom_range(1) ? ilp_pkg::CH_PLUS : ilp_pkg::CH_MINUS);
    endcase
  endtask

  // stimulus
  initial begin
    char_q_t chars;
    int      target;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    s_tuser  = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed corners
    send_text("", 1'b0);
    send_text("-0", 1'b0);
    send_text("+", 1'b0);
    send_text("0B", 1'b0);
    send_text("012", 1'b0);
    send_text("0xFf", 1'b0);
    send_text("-0o7", 1'b0);
    send_text("0b12", 1'b0);
    send_text("7", 1'b1);
    send_item(ilp_pkg::CH_ZERO, 1'b0, 1'b1);
    send_text("a", 1'b0);

    // random strings in four idling mixes
    for (int mix = 0; mix < 4; mix++) begin
      send_idle_pct  = (mix == 1) ? 61 : (mix == 3) ? 33 : 0;
      recv_stall_pct = (mix == 2) ? 61 : (mix == 3) ? 33 : 0;
      if (mix == 0) hold_request = 1'b1;
      target = items_sent + RANDOM_ITEMS / 4;
      while (items_sent < target) begin
        build_literal(chars);
        if ($urandom_range(32) == 0) chars = {};
        send_string(chars, $urandom_range(9) == 0);
      end
    end
    s_tvalid <= 1'b0;

    // drain
    recv_stall_pct = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("tb_integer_literal_parser: done, clean");
    end else begin
      $display("tb_integer_literal_parser: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/ilp_pkg.sv
src/ilp_step.sv
src/ilp_out.sv
src/integer_literal_parser.sv
tb/sv/tb_integer_literal_parser.sv
